### hw/rtl/lfcc_pkg.sv
package lfcc_pkg;

	// widths of the stream payloads
	localparam int unsigned IN_DATA_W  = 48;
	localparam int unsigned IN_USER_W  = 3;
	localparam int unsigned OUT_DATA_W = 48;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [2:0] {
		ACT_TICK       = 3'd0,
		ACT_CHANGE_COL = 3'd1,
		ACT_ADJUST     = 3'd2,
		ACT_SETUP      = 3'd3,
		ACT_CLEAR_REQ  = 3'd4,
		ACT_TOGGLE_PWR = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		CFG_MIN_LEVEL     = 3'd0,
		CFG_MAX_LEVEL     = 3'd1,
		CFG_RAMP_STEP     = 3'd2,
		CFG_RAMP_INTERVAL = 3'd3,
		CFG_STORE_DELAY   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_FADE_OUT  = 2'd1,
		PH_SET_COLOR = 2'd2,
		PH_FADE_IN   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0]  now_level;
		logic [7:0]  aim_level;
		logic [7:0]  kept_level;
		logic [23:0] now_color;
		logic [23:0] aim_color;
		phase_t      phase;
		logic [15:0] ramp_count;
		logic [15:0] store_count;
		logic        watching;
		logic        request_flag;
		logic        powered;
	} state_t;

	localparam state_t STATE_RST = '{
		now_level:    8'd0,
		aim_level:    8'd0,
		kept_level:   8'd0,
		now_color:    24'd0,
		aim_color:    24'd0,
		phase:        PH_IDLE,
		ramp_count:   16'd0,
		store_count:  16'd0,
		watching:     1'b0,
		request_flag: 1'b0,
		powered:      1'b0
	};

	localparam logic [7:0]  MIN_LEVEL_RST     = 8'd5;
	localparam logic [7:0]  MAX_LEVEL_RST     = 8'd255;
	localparam logic [7:0]  RAMP_STEP_RST     = 8'd5;
	localparam logic [15:0] RAMP_INTERVAL_RST = 16'd10;
	localparam logic [15:0] STORE_DELAY_RST   = 16'd5000;

endpackage

### hw/rtl/led_fade_color_controller.sv
// led strip fade and colour controller
// input channel s_axis: one transaction is one command; s_axis_tuser carries the
// action code (tick, change colour, relative brightness, setup, clear request,
// toggle power) and s_axis_tdata its operands. every command gives exactly one
// result transaction on m_axis: the shown and goal brightness, shown colour,
// fade phase, power enable and storing request as they stand after the command.
// ticks are the only notion of time: ramp steps, the colour fade sequence and
// the store delay all advance on tick commands (and on the tick inside setup)
// a command taken into the command register is evaluated by a short
// combinational update of the state registers as it moves on, and its result
// is registered in the result register
// throughput: one command per cycle while m_axis_tready is high; the command
// and result registers form a two-entry pipeline, so a new command is taken
// while a result waits whenever the command register moves on in the same cycle
// when m_axis_tready is low the result holds and the command register fills,
// after which s_axis_tready drops until the result is taken
// reset (arst_n low) clears brightness, colours, timers and flags, puts the fade
// sequence to idle, empties both pipeline registers and loads the register
// defaults; configuration writes via cfg_we take effect at once and are meant
// for when the block is idle
module led_fade_color_controller (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [lfcc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [lfcc_pkg::CFG_DATA_W-1:0]     cfg_data,
	// command channel
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata from bit 0: color[23:0], force_fade[24], level_delta[33:25],
	// level[41:34], zero fill[47:42]
	input  logic [lfcc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// tuser from bit 0: action[2:0]
	input  logic [lfcc_pkg::IN_USER_W-1:0]      s_axis_tuser,
	// result channel
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// tdata from bit 0: shown_level[7:0], goal_level[15:8], shown_color[39:16],
	// fade_phase[41:40], power_enable[42], store_request[43], zero fill[47:44]
	output logic [lfcc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	// configuration registers
	logic [7:0]  min_level_q;
	logic [7:0]  max_level_q;
	logic [7:0]  ramp_step_q;
	logic [15:0] ramp_interval_q;
	logic [15:0] store_delay_q;

	// command register
	logic                  valid_s1;
	lfcc_pkg::action_t     action_s1;
	logic [23:0]           color_s1;
	logic                  force_s1;
	logic signed [8:0]     delta_s1;
	logic [7:0]            level_s1;

	// controller state and its next value
	lfcc_pkg::state_t      st_q;
	lfcc_pkg::state_t      st_d;
	lfcc_pkg::state_t      setup_st;

	// result register
	logic                           out_valid_q;
	logic [lfcc_pkg::OUT_DATA_W-1:0] out_data_q;

	logic advance;
	logic take_in;

	logic signed [10:0] adj_sum;
	logic [23:0]        req_color;

	// one tick evaluation: count timers down, then ramp, else sequence, else store
	function automatic lfcc_pkg::state_t do_tick(
		input lfcc_pkg::state_t s,
		input logic [7:0]       min_lvl,
		input logic [7:0]       step,
		input logic [15:0]      interval
	);
		lfcc_pkg::state_t r;
		logic [8:0]       up;
		logic [8:0]       dn;
		r  = s;
		up = {1'b0, s.now_level} + {1'b0, step};
		dn = {1'b0, s.now_level} - {1'b0, step};
		if (r.ramp_count != 16'd0) begin
			r.ramp_count = r.ramp_count - 16'd1;
		end
		if (r.store_count != 16'd0) begin
			r.store_count = r.store_count - 16'd1;
		end
		if (r.now_level != r.aim_level) begin
			if (r.ramp_count == 16'd0) begin
				if (r.aim_level > r.now_level) begin
					r.now_level = (up > {1'b0, r.aim_level}) ? r.aim_level : up[7:0];
				end else begin
					// borrow out means it went below zero, so below the goal too
					r.now_level = (dn[8] || (dn[7:0] < r.aim_level)) ? r.aim_level
						: dn[7:0];
				end
				r.ramp_count = interval;
			end
		end else if (r.phase != lfcc_pkg::PH_IDLE) begin
			unique case (r.phase)
				lfcc_pkg::PH_FADE_OUT: begin
					r.kept_level = r.now_level;
					r.aim_level  = min_lvl;
					r.phase      = lfcc_pkg::PH_SET_COLOR;
				end
				lfcc_pkg::PH_SET_COLOR: begin
					if (r.now_level <= r.aim_level) begin
						r.now_color = r.aim_color;
						r.aim_level = r.kept_level;
						r.phase     = lfcc_pkg::PH_FADE_IN;
					end
				end
				lfcc_pkg::PH_FADE_IN: begin
					if (r.now_level >= r.aim_level) begin
						r.now_color = r.aim_color;
						r.phase     = lfcc_pkg::PH_IDLE;
					end
				end
				lfcc_pkg::PH_IDLE: begin
					r.phase = lfcc_pkg::PH_IDLE;
				end
			endcase
		end else if (r.watching && (r.store_count == 16'd0)) begin
			r.watching     = 1'b0;
			r.request_flag = 1'b1;
		end
		return r;
	endfunction

	// the command register moves on when the result register is free or emptying
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign take_in       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	// configuration writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q     <= lfcc_pkg::MIN_LEVEL_RST;
			max_level_q     <= lfcc_pkg::MAX_LEVEL_RST;
			ramp_step_q     <= lfcc_pkg::RAMP_STEP_RST;
			ramp_interval_q <= lfcc_pkg::RAMP_INTERVAL_RST;
			store_delay_q   <= lfcc_pkg::STORE_DELAY_RST;
		end else if (cfg_we) begin
			unique case (lfcc_pkg::cfg_reg_t'(cfg_idx))
				lfcc_pkg::CFG_MIN_LEVEL:     min_level_q     <= cfg_data[7:0];
				lfcc_pkg::CFG_MAX_LEVEL:     max_level_q     <= cfg_data[7:0];
				lfcc_pkg::CFG_RAMP_STEP:     ramp_step_q     <= cfg_data[7:0];
				lfcc_pkg::CFG_RAMP_INTERVAL: ramp_interval_q <= cfg_data;
				lfcc_pkg::CFG_STORE_DELAY:   store_delay_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			action_s1 <= lfcc_pkg::action_t'(s_axis_tuser);
			color_s1  <= s_axis_tdata[23:0];
			force_s1  <= s_axis_tdata[24];
			delta_s1  <= s_axis_tdata[33:25];
			level_s1  <= s_axis_tdata[41:34];
		end
	end

	// relative brightness sum, wide enough for any level and delta
	assign adj_sum   = $signed({3'b000, st_q.now_level}) + 11'(delta_s1);
	// toggle off asks for black, toggle on for the colour in the command
	assign req_color = st_q.powered ? 24'd0 : color_s1;

	always_comb begin
		setup_st           = st_q;
		setup_st.now_level = level_s1;
		setup_st.aim_level = level_s1;
		setup_st.now_color = color_s1;
		setup_st.aim_color = color_s1;
	end

	// state update for the command in the command register
	always_comb begin
		st_d = st_q;
		unique case (action_s1)
			lfcc_pkg::ACT_TICK: begin
				st_d = do_tick(st_q, min_level_q, ramp_step_q, ramp_interval_q);
			end
			lfcc_pkg::ACT_CHANGE_COL: begin
				// colour requests are ignored while a fade is running
				if (st_q.phase == lfcc_pkg::PH_IDLE) begin
					st_d.aim_color = color_s1;
					if ((color_s1 != st_q.now_color) || force_s1) begin
						st_d.phase = lfcc_pkg::PH_FADE_OUT;
					end
				end
			end
			lfcc_pkg::ACT_ADJUST: begin
				// lower bound wins when min is above max
				if (adj_sum < $signed({3'b000, min_level_q})) begin
					st_d.now_level = min_level_q;
				end else if (adj_sum > $signed({3'b000, max_level_q})) begin
					st_d.now_level = max_level_q;
				end else begin
					st_d.now_level = adj_sum[7:0];
				end
				st_d.aim_level   = st_d.now_level;
				st_d.watching    = 1'b1;
				st_d.store_count = store_delay_q;
			end
			lfcc_pkg::ACT_SETUP: begin
				st_d = do_tick(setup_st, min_level_q, ramp_step_q, ramp_interval_q);
			end
			lfcc_pkg::ACT_CLEAR_REQ: begin
				st_d.request_flag = 1'b0;
			end
			lfcc_pkg::ACT_TOGGLE_PWR: begin
				st_d.powered = !st_q.powered;
				if (st_q.phase == lfcc_pkg::PH_IDLE) begin
					st_d.aim_color = req_color;
					if (req_color != st_q.now_color) begin
						st_d.phase = lfcc_pkg::PH_FADE_OUT;
					end
				end
			end
			default: begin
				// unused action codes leave the state alone
				st_d = st_q;
			end
		endcase
	end

	// state registers follow the command as it leaves the command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= lfcc_pkg::STATE_RST;
		end else if (advance) begin
			st_q <= st_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {4'b0000, st_d.request_flag, st_d.powered, st_d.phase,
				st_d.now_color, st_d.aim_level, st_d.now_level};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// with no fade running the shown brightness has settled on the goal
	a_idle_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == lfcc_pkg::PH_IDLE) |-> (st_q.now_level == st_q.aim_level))
		else $error("idle fade phase with brightness off its goal");

	// the fade sequence only leaves idle through fade out
	a_fade_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == lfcc_pkg::PH_IDLE) |=>
		((st_q.phase == lfcc_pkg::PH_IDLE) || (st_q.phase == lfcc_pkg::PH_FADE_OUT)))
		else $error("fade sequence skipped fade out");

	// a command leaving the command register always lands in the result register
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("command evaluated without a result");

	// the storing request is only raised by a tick evaluation
	a_request_by_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st_q.request_flag) |->
		$past(advance && ((action_s1 == lfcc_pkg::ACT_TICK) ||
			(action_s1 == lfcc_pkg::ACT_SETUP))))
		else $error("storing request raised outside a tick");

	// state only changes when a command is evaluated
	a_state_held: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(st_q))
		else $error("state changed with no command");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

// testbench for the led fade and colour controller
// commands go in on s_axis, one result per command comes back on m_axis
// a behavioural model of the controller predicts every result

module tb_top;

	// tuser codes the block does not use, they must leave the state alone
	localparam logic [2:0] ACT_SPARE_A = 3'd6;
	localparam logic [2:0] ACT_SPARE_B = 3'd7;

	// cycles without any transaction before the run is called hung
	localparam int unsigned HANG_LIMIT = 5000;

	// one expected result transaction
	typedef struct {
		logic [7:0]        shown;
		logic [7:0]        goal;
		logic [23:0]       colour;
		lfcc_pkg::phase_t  phase;
		logic              power;
		logic              store_req;
	} strip_view_t;

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [lfcc_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [lfcc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            s_valid = 1'b0;
	logic                            s_ready;
	logic [lfcc_pkg::IN_DATA_W-1:0]  s_data = '0;
	logic [lfcc_pkg::IN_USER_W-1:0]  s_user = '0;
	logic                            m_valid;
	logic                            m_ready = 1'b0;
	logic [lfcc_pkg::OUT_DATA_W-1:0] m_data;

	// idling controls, both on unless a test turns them off
	bit gaps_on  = 1'b1;
	bit stall_on = 1'b1;

	// model copy of the control registers
	logic [7:0]  reg_min;
	logic [7:0]  reg_max;
	logic [7:0]  reg_step;
	logic [15:0] reg_interval;
	logic [15:0] reg_delay;

	// model copy of the controller state
	logic [7:0]        lvl_now;
	logic [7:0]        lvl_aim;
	logic [7:0]        lvl_kept;
	logic [23:0]       col_now;
	logic [23:0]       col_aim;
	lfcc_pkg::phase_t  fade_ph;
	logic [15:0]       ramp_cnt;
	logic [15:0]       store_cnt;
	logic              store_armed;
	logic              store_req;
	logic              pwr_on;

	strip_view_t view_q[$];

	int unsigned n_cmds    = 0;
	int unsigned n_views   = 0;
	int unsigned n_errors  = 0;
	int unsigned n_fades   = 0;
	int unsigned n_stores  = 0;
	int unsigned n_configs = 0;
	int unsigned hang_cnt  = 0;

	led_fade_color_controller u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.s_axis_tuser  (s_user),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------- model

	// a colour request only starts a fade when the sequence is idle
	function automatic void request_colour(logic [23:0] c, bit frc);
		if (fade_ph == lfcc_pkg::PH_IDLE) begin
			col_aim = c;
			if (col_aim != col_now || frc)
				fade_ph = lfcc_pkg::PH_FADE_OUT;
		end
	endfunction

	// one ramp step toward the goal, clamped at the goal, then the timer reloads
	function automatic void ramp_level();
		int v;
		int aim;
		aim = int'(lvl_aim);
		if (ramp_cnt == 16'd0) begin
			if (lvl_aim > lvl_now) begin
				v = int'(lvl_now) + int'(reg_step);
				lvl_now = (v > aim) ? lvl_aim : v[7:0];
			end else if (lvl_aim < lvl_now) begin
				v = int'(lvl_now) - int'(reg_step);
				lvl_now = (v < aim) ? lvl_aim : v[7:0];
			end
			ramp_cnt = reg_interval;
		end
	endfunction

	// colour change: fade out to the minimum, swap colour, fade back in
	function automatic void fade_step();
		case (fade_ph)
			lfcc_pkg::PH_FADE_OUT: begin
				lvl_kept = lvl_now;
				lvl_aim  = reg_min;
				fade_ph  = lfcc_pkg::PH_SET_COLOR;
			end
			lfcc_pkg::PH_SET_COLOR: begin
				if (lvl_now <= lvl_aim) begin
					col_now = col_aim;
					lvl_aim = lvl_kept;
					fade_ph = lfcc_pkg::PH_FADE_IN;
				end
			end
			lfcc_pkg::PH_FADE_IN: begin
				if (lvl_now >= lvl_aim) begin
					col_now = col_aim;
					fade_ph = lfcc_pkg::PH_IDLE;
					n_fades++;
				end
			end
			default: fade_ph = lfcc_pkg::PH_IDLE;
		endcase
	endfunction

	// a tick: timers count down, then ramp, fade or raise the storing request
	function automatic void tick_eval();
		if (ramp_cnt != 16'd0)
			ramp_cnt--;
		if (store_cnt != 16'd0)
			store_cnt--;
		if (lvl_now != lvl_aim) begin
			ramp_level();
		end else if (fade_ph != lfcc_pkg::PH_IDLE) begin
			fade_step();
		end else if (store_armed && store_cnt == 16'd0) begin
			store_armed = 1'b0;
			store_req   = 1'b1;
			n_stores++;
		end
	endfunction

	// relative brightness, lower bound first so min above max gives min
	function automatic void adjust_level(logic signed [8:0] dlt);
		int v;
		v = int'(lvl_now) + int'(dlt);
		if (v < int'(reg_min))
			lvl_now = reg_min;
		else if (v > int'(reg_max))
			lvl_now = reg_max;
		else
			lvl_now = v[7:0];
		lvl_aim     = lvl_now;
		store_armed = 1'b1;
		store_cnt   = reg_delay;
	endfunction

	function automatic strip_view_t predict_view(logic [2:0] act, logic [23:0] col, bit frc,
			logic [8:0] dlt, logic [7:0] lvl);
		strip_view_t v;
		case (act)
			lfcc_pkg::ACT_TICK:       tick_eval();
			lfcc_pkg::ACT_CHANGE_COL: request_colour(col, frc);
			lfcc_pkg::ACT_ADJUST:     adjust_level(dlt);
			lfcc_pkg::ACT_SETUP: begin
				lvl_now = lvl;
				lvl_aim = lvl;
				col_now = col;
				col_aim = col;
				tick_eval();
			end
			lfcc_pkg::ACT_CLEAR_REQ:  store_req = 1'b0;
			lfcc_pkg::ACT_TOGGLE_PWR: begin
				if (pwr_on) begin
					pwr_on = 1'b0;
					request_colour(24'd0, 1'b0);
				end else begin
					pwr_on = 1'b1;
					request_colour(col, 1'b0);
				end
			end
			default: ;
		endcase
		v.shown     = lvl_now;
		v.goal      = lvl_aim;
		v.colour    = col_now;
		v.phase     = fade_ph;
		v.power     = pwr_on;
		v.store_req = store_req;
		return v;
	endfunction

	// ---------------------------------------------------------------- driving

	// result side back-pressure, tready low with a chance of 30 in a hundred when enabled
	always @(posedge clk) begin
		m_ready <= stall_on ? ($urandom_range(99) >= 30) : 1'b1;
	end

	// one command transaction; called just after a rising edge
	task automatic send_cmd(logic [2:0] act, logic [23:0] col, bit frc, logic [8:0] dlt,
			logic [7:0] lvl);
		if (gaps_on && $urandom_range(99) < 30) begin
			s_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		s_valid <= 1'b1;
		s_user  <= act;
		s_data  <= {6'd0, lvl, dlt, frc, col};
		@(posedge clk);
		while (!s_ready)
			@(posedge clk);
		view_q.push_back(predict_view(act, col, frc, dlt, lvl));
		n_cmds++;
	endtask

	// hold off until every result is back, then let the pipeline settle
	task automatic wait_drained();
		s_valid <= 1'b0;
		while (view_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// all five registers, written only once the block is idle
	task automatic apply_settings(logic [7:0] mn, logic [7:0] mx, logic [7:0] st,
			logic [15:0] iv, logic [15:0] dl);
		wait_drained();
		cfg_we   <= 1'b1;
		cfg_idx  <= lfcc_pkg::CFG_MIN_LEVEL;
		cfg_data <= {8'd0, mn};
		@(posedge clk);
		cfg_idx  <= lfcc_pkg::CFG_MAX_LEVEL;
		cfg_data <= {8'd0, mx};
		@(posedge clk);
		cfg_idx  <= lfcc_pkg::CFG_RAMP_STEP;
		cfg_data <= {8'd0, st};
		@(posedge clk);
		cfg_idx  <= lfcc_pkg::CFG_RAMP_INTERVAL;
		cfg_data <= iv;
		@(posedge clk);
		cfg_idx  <= lfcc_pkg::CFG_STORE_DELAY;
		cfg_data <= dl;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		reg_min      = mn;
		reg_max      = mx;
		reg_step     = st;
		reg_interval = iv;
		reg_delay    = dl;
		n_configs++;
	endtask

	// random command mix, ticks dominate so fades and store delays run through
	task automatic send_random_cmd();
		logic [2:0]  act;
		logic [23:0] col;
		logic [7:0]  lvl;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 50)
			act = lfcc_pkg::ACT_TICK;
		else if (pick < 60)
			act = lfcc_pkg::ACT_CHANGE_COL;
		else if (pick < 72)
			act = lfcc_pkg::ACT_ADJUST;
		else if (pick < 77)
			act = lfcc_pkg::ACT_SETUP;
		else if (pick < 84)
			act = lfcc_pkg::ACT_CLEAR_REQ;
		else if (pick < 94)
			act = lfcc_pkg::ACT_TOGGLE_PWR;
		else if (pick < 97)
			act = ACT_SPARE_A;
		else
			act = ACT_SPARE_B;
		pick = $urandom_range(99);
		// same colour now and then, so the no-change path is hit too
		if (pick < 25)
			col = col_now;
		else if (pick < 30)
			col = 24'd0;
		else if (pick < 35)
			col = 24'hFFFFFF;
		else
			col = 24'($urandom_range(24'hFFFFFF));
		pick = $urandom_range(99);
		if (pick < 10)
			lvl = 8'd0;
		else if (pick < 20)
			lvl = 8'd255;
		else
			lvl = 8'($urandom_range(255));
		send_cmd(act, col, 1'($urandom_range(1)), 9'($urandom_range(511)), lvl);
	endtask

	task automatic run_random(int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			// now and then the sender waits for every result to come back
			if (i != 0 && i % 250 == 0)
				wait_drained();
			send_random_cmd();
		end
	endtask

	// ---------------------------------------------------------------- checking

	always @(posedge clk) begin : check_views
		strip_view_t want;
		if (arst_n && m_valid && m_ready) begin
			n_views++;
			if (view_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result transaction: %h", m_data);
			end else begin
				want = view_q.pop_front();
				if (m_data[7:0] !== want.shown || m_data[15:8] !== want.goal ||
						m_data[39:16] !== want.colour || m_data[41:40] !== want.phase ||
						m_data[42] !== want.power || m_data[43] !== want.store_req ||
						m_data[47:44] !== 4'd0) begin
					n_errors++;
					if (n_errors <= 10) begin
						$display("result %0d exp shown %0d goal %0d colour %h phase %0d power %b req %b",
							n_views, want.shown, want.goal, want.colour, want.phase,
							want.power, want.store_req);
						$display("result %0d got shown %0d goal %0d colour %h phase %0d power %b req %b fill %h",
							n_views, m_data[7:0], m_data[15:8], m_data[39:16],
							m_data[41:40], m_data[42], m_data[43], m_data[47:44]);
					end
				end
			end
		end
	end

	// hang watchdog: any transaction on either side resets the count
	always @(posedge clk) begin
		if ((s_valid && s_ready) || (m_valid && m_ready))
			hang_cnt <= 0;
		else
			hang_cnt <= hang_cnt + 1;
		if (hang_cnt >= HANG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", HANG_LIMIT);
			$display("** led_fade_color_controller: FAILED **");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// state straight after reset, and the two unused codes
	task automatic test_power_up();
		send_cmd(lfcc_pkg::ACT_TICK, 24'h000000, 1'b0, 9'd0, 8'd0);
		send_cmd(ACT_SPARE_A, 24'hFFFFFF, 1'b1, 9'h1FF, 8'd255);
		send_cmd(ACT_SPARE_B, 24'hA5A5A5, 1'b1, 9'h100, 8'd170);
	endtask

	task automatic test_corner_cases();
		// ramp on every tick, big steps, short store delay
		apply_settings(8'd10, 8'd240, 8'd60, 16'd0, 16'd2);
		send_cmd(lfcc_pkg::ACT_SETUP, 24'hFFFFFF, 1'b1, 9'h100, 8'd255);
		send_cmd(lfcc_pkg::ACT_ADJUST, 24'h000000, 1'b0, 9'd255, 8'd0);    // clamp at max
		send_cmd(lfcc_pkg::ACT_ADJUST, 24'h000000, 1'b0, -9'sd255, 8'd0);  // clamp at min
		send_cmd(lfcc_pkg::ACT_ADJUST, 24'h000000, 1'b0, 9'h100, 8'd0);    // most negative
		send_cmd(lfcc_pkg::ACT_ADJUST, 24'h000000, 1'b0, 9'd200, 8'd0);
		// unchanged colour: no fade unless forced
		send_cmd(lfcc_pkg::ACT_CHANGE_COL, 24'hFFFFFF, 1'b0, 9'd0, 8'd0);
		send_cmd(lfcc_pkg::ACT_CHANGE_COL, 24'hFFFFFF, 1'b1, 9'd0, 8'd0);
		// while busy a colour request is dropped, toggle still flips power
		send_cmd(lfcc_pkg::ACT_CHANGE_COL, 24'h123456, 1'b0, 9'd0, 8'd0);
		send_cmd(lfcc_pkg::ACT_TOGGLE_PWR, 24'h654321, 1'b0, 9'd0, 8'd0);
		repeat (8)
			send_cmd(lfcc_pkg::ACT_TICK, 24'h000000, 1'b0, 9'd0, 8'd0);
		send_cmd(lfcc_pkg::ACT_CLEAR_REQ, 24'h000000, 1'b0, 9'd0, 8'd0);
		send_cmd(lfcc_pkg::ACT_SETUP, 24'h000000, 1'b0, 9'd0, 8'd0);
		// toggle off asks for black, already black so no fade
		send_cmd(lfcc_pkg::ACT_TOGGLE_PWR, 24'h00FF00, 1'b0, 9'd0, 8'd0);
		// adjust then let the store delay run out
		send_cmd(lfcc_pkg::ACT_ADJUST, 24'h000000, 1'b0, 9'd1, 8'd0);
		repeat (3)
			send_cmd(lfcc_pkg::ACT_TICK, 24'h000000, 1'b0, 9'd0, 8'd0);
		send_cmd(lfcc_pkg::ACT_CLEAR_REQ, 24'h000000, 1'b0, 9'd0, 8'd0);
	endtask

	task automatic test_default_settings();
		apply_settings(lfcc_pkg::MIN_LEVEL_RST, lfcc_pkg::MAX_LEVEL_RST,
			lfcc_pkg::RAMP_STEP_RST, lfcc_pkg::RAMP_INTERVAL_RST,
			lfcc_pkg::STORE_DELAY_RST);
		run_random(150);
	endtask

	// register extremes, including min above max
	task automatic test_extreme_settings();
		apply_settings(8'd0, 8'd255, 8'd255, 16'd0, 16'd0);
		run_random(120);
		apply_settings(8'd255, 8'd255, 8'd1, 16'hFFFF, 16'hFFFF);
		run_random(100);
		apply_settings(8'd255, 8'd0, 8'd1, 16'd0, 16'd0);
		run_random(80);
		apply_settings(8'd200, 8'd50, 8'd7, 16'd1, 16'd3);
		run_random(80);
	endtask

	// long stretch at full rate on both sides
	task automatic test_full_rate();
		apply_settings(8'd3, 8'd250, 8'd20, 16'd1, 16'd12);
		gaps_on  = 1'b0;
		stall_on = 1'b0;
		run_random(300);
		wait_drained();
		gaps_on  = 1'b1;
		stall_on = 1'b1;
	endtask

	task automatic test_random_settings();
		repeat (8) begin
			apply_settings(8'($urandom_range(60)), 8'($urandom_range(150, 255)),
				8'($urandom_range(1, 64)), 16'($urandom_range(3)),
				16'($urandom_range(40)));
			run_random(110);
		end
	endtask

	initial begin
		reg_min      = lfcc_pkg::MIN_LEVEL_RST;
		reg_max      = lfcc_pkg::MAX_LEVEL_RST;
		reg_step     = lfcc_pkg::RAMP_STEP_RST;
		reg_interval = lfcc_pkg::RAMP_INTERVAL_RST;
		reg_delay    = lfcc_pkg::STORE_DELAY_RST;
		lvl_now      = 8'd0;
		lvl_aim      = 8'd0;
		lvl_kept     = 8'd0;
		col_now      = 24'd0;
		col_aim      = 24'd0;
		fade_ph      = lfcc_pkg::PH_IDLE;
		ramp_cnt     = 16'd0;
		store_cnt    = 16'd0;
		store_armed  = 1'b0;
		store_req    = 1'b0;
		pwr_on       = 1'b0;

		// reset held low at the start, then released
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_up();
		test_corner_cases();
		test_default_settings();
		test_extreme_settings();
		test_full_rate();
		test_random_settings();

		wait_drained();
		repeat (10) @(posedge clk);
		n_errors += view_q.size();

		$display("covered %0d commands and %0d results over %0d register settings",
			n_cmds, n_views, n_configs);
		$display("model saw %0d completed colour fades and %0d storing requests, %0d errors",
			n_fades, n_stores, n_errors);
		if (n_errors == 0)
			$display("** led_fade_color_controller: PASSED **");
		else
			$display("** led_fade_color_controller: FAILED **");
		$finish;
	end

endmodule
